[hw/rtl/wcht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcht_pkg
// shared types and codes of the word count hash table
// ----------------------------------------------------------------------------
package wcht_pkg;

    // number of table slots, fixed by the 10 bit slot field of the result
    localparam int TABLE_ENTRIES = 1024;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    // unused command, behaves as find
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_INC     = 3'd1;
    localparam logic [2:0] ST_FOUND   = 3'd2;
    localparam logic [2:0] ST_MISS    = 3'd3;
    localparam logic [2:0] ST_DELETED = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;
    localparam logic [2:0] ST_LONG    = 3'd6;

    localparam logic [63:0] HASH_SEED  = 64'd5381;
    localparam int          HASH_SHIFT = 5;
    localparam logic [31:0] SAT32      = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SLOT_RD,
        S_SLOT_WAIT,
        S_SLOT_CHK,
        S_KEY_WAIT,
        S_KEY_CHK,
        S_STORE,
        S_CNT_WAIT,
        S_COUNT,
        S_OUT
    } state_t;

endpackage : wcht_pkg
`default_nettype wire

[hw/rtl/word_count_hash_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// word_count_hash_table
// djb2 hashed word counter with linear probing
// ----------------------------------------------------------------------------
// Words arrive on the s_axis channel one byte per transfer, tlast marking the
// final byte and tuser the command (insert, find, delete). At the final byte
// the home slot is hash mod TABLE_ENTRIES and a sequencer walks the table
// through rams with one write port and one registered read port: it reads a
// slot's valid flag and length, ends the walk at an empty slot, moves on to
// the next slot on a length or key byte mismatch, and else compares the key
// one byte at a time. Then a new word is stored byte by byte with its length,
// a count of one and its valid flag, while a found word has its count raised
// (insert), read (find) or its slot emptied (delete). An overlong word skips
// the walk. The result is registered. One result per word is held on m_axis
// until taken; s_axis is not ready while a word is being processed, and a
// finished word waits in its last step while the previous result is held.
// After reset a clearing pass over all TABLE_ENTRIES (1024) slots empties the
// slot valid store before s_axis becomes ready; key, length and count stores
// start undefined.
// ----------------------------------------------------------------------------
module word_count_hash_table #(
    parameter int WORD_BYTES    = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // char_byte
    input  wire logic        s_axis_tlast,   // last_char
    input  wire logic [1:0]  s_axis_tuser,   // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [111:0]     m_axis_tdata,   // slot[9:0], word_count, total_words,
                                             // distinct_words, zero fill
    output logic [2:0]       m_axis_tuser    // status
);
    localparam int TABLE_ENTRIES = wcht_pkg::TABLE_ENTRIES;
    localparam int SW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int BW = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
    localparam int LW = $clog2(WORD_BYTES + 1);
    localparam int KW = SW + BW;
    localparam int PW = SW + 1;

    wcht_pkg::state_t state_reg, state_next;

    logic [63:0]  hash_reg;
    logic [LW-1:0] len_reg;
    logic         long_reg;
    logic [1:0]   cmd_reg;
    logic [7:0]   wbuf_reg [WORD_BYTES];
    logic [SW-1:0] slot_reg, slot_next;
    logic [PW-1:0] probe_reg, probe_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [31:0]  total_reg, distinct_reg;
    logic [2:0]   ost_reg;
    logic [SW-1:0] oslot_reg;
    logic [31:0]  ocnt_reg;
    logic         ovalid_reg;
    logic [2:0]   m_st_reg;
    logic [SW-1:0] m_slot_reg;
    logic [31:0]  m_cnt_reg, m_tot_reg, m_dis_reg;

    logic [63:0]  hash_new;
    logic         acc;
    logic         out_load;

    // ram ports
    logic          key_we, len_we, cnt_we, vld_we;
    logic [KW-1:0] key_waddr, key_raddr;
    logic [7:0]    key_rdata;
    logic [LW-1:0] len_rdata;
    logic [31:0]   cnt_wdata, cnt_rdata;
    logic          vld_wdata, vld_rdata;

    assign acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == wcht_pkg::S_IDLE);
    // the finished word moves to the output once the previous one is gone or is being taken
    assign out_load = (state_reg == wcht_pkg::S_OUT) && (!ovalid_reg || m_axis_tready);
    assign hash_new = (hash_reg << wcht_pkg::HASH_SHIFT) + hash_reg
                      + {56'd0, s_axis_tdata};

    wcht_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * (2 ** BW))) u_key (
        .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(wbuf_reg[idx_reg[BW-1:0]]),
        .raddr(key_raddr), .rdata(key_rdata)
    );
    wcht_ram #(.WIDTH(LW), .DEPTH(TABLE_ENTRIES)) u_len (
        .clk(clk), .we(len_we), .waddr(slot_reg), .wdata(len_reg),
        .raddr(slot_reg), .rdata(len_rdata)
    );
    wcht_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(slot_reg), .wdata(cnt_wdata),
        .raddr(slot_reg), .rdata(cnt_rdata)
    );
    wcht_ram #(.WIDTH(1), .DEPTH(TABLE_ENTRIES)) u_vld (
        .clk(clk), .we(vld_we), .waddr(slot_reg), .wdata(vld_wdata),
        .raddr(slot_reg), .rdata(vld_rdata)
    );

    assign key_waddr = {slot_reg, idx_reg[BW-1:0]};
    assign key_raddr = {slot_reg, idx_next[BW-1:0]};
    assign vld_wdata = (state_reg == wcht_pkg::S_STORE);

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        probe_next = probe_reg;
        idx_next   = idx_reg;
        key_we = 1'b0;
        len_we = 1'b0;
        cnt_we = 1'b0;
        vld_we = 1'b0;
        cnt_wdata = 32'd1;
        case (state_reg)
            wcht_pkg::S_CLEAR:
            begin
                // clearing pass over the slot valid store
                vld_we    = 1'b1;
                slot_next = slot_reg + SW'(1);
                if (slot_reg == SW'(TABLE_ENTRIES - 1))
                    state_next = wcht_pkg::S_IDLE;
            end
            wcht_pkg::S_IDLE:
            begin
                idx_next = '0;
                if (acc && s_axis_tlast)
                begin
                    state_next = wcht_pkg::S_SLOT_RD;
                    slot_next  = SW'(hash_new % 64'(TABLE_ENTRIES));
                    probe_next = '0;
                end
            end
            wcht_pkg::S_SLOT_RD:
            begin
                idx_next = '0;
                if (long_reg)
                    state_next = wcht_pkg::S_OUT;
                else if (probe_reg == PW'(TABLE_ENTRIES))
                    state_next = wcht_pkg::S_OUT;
                else
                    state_next = wcht_pkg::S_SLOT_WAIT;
            end
            wcht_pkg::S_SLOT_WAIT:
            begin
                if (!vld_rdata)
                    state_next = (cmd_reg == wcht_pkg::CMD_INSERT) ?
                                 wcht_pkg::S_STORE : wcht_pkg::S_OUT;
                else
                    state_next = wcht_pkg::S_SLOT_CHK;
            end
            wcht_pkg::S_SLOT_CHK:
            begin
                if (len_rdata != len_reg)
                    state_next = wcht_pkg::S_KEY_CHK;
                else if (idx_reg == len_reg)
                    state_next = wcht_pkg::S_CNT_WAIT;
                else
                    state_next = wcht_pkg::S_KEY_WAIT;
                if (len_rdata != len_reg)
                begin
                    // length mismatch: next slot
                    state_next = wcht_pkg::S_SLOT_RD;
                    probe_next = probe_reg + PW'(1);
                    slot_next  = (slot_reg == SW'(TABLE_ENTRIES - 1)) ? '0
                                 : slot_reg + SW'(1);
                end
            end
            wcht_pkg::S_KEY_WAIT:
                state_next = wcht_pkg::S_KEY_CHK;
            wcht_pkg::S_KEY_CHK:
            begin
                if (key_rdata != wbuf_reg[idx_reg[BW-1:0]])
                begin
                    state_next = wcht_pkg::S_SLOT_RD;
                    probe_next = probe_reg + PW'(1);
                    slot_next  = (slot_reg == SW'(TABLE_ENTRIES - 1)) ? '0
                                 : slot_reg + SW'(1);
                end
                else if (idx_reg + LW'(1) == len_reg)
                begin
                    state_next = wcht_pkg::S_CNT_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + LW'(1);
                    state_next = wcht_pkg::S_KEY_WAIT;
                end
            end
            wcht_pkg::S_STORE:
            begin
                key_we = 1'b1;
                if (idx_reg + LW'(1) >= len_reg)
                begin
                    len_we = 1'b1;
                    cnt_we = 1'b1;
                    vld_we = 1'b1;
                    state_next = wcht_pkg::S_OUT;
                end
                else
                begin
                    idx_next = idx_reg + LW'(1);
                end
            end
            wcht_pkg::S_CNT_WAIT:
                state_next = wcht_pkg::S_COUNT;
            wcht_pkg::S_COUNT:
            begin
                cnt_wdata = (cnt_rdata == wcht_pkg::SAT32) ? cnt_rdata
                            : cnt_rdata + 32'd1;
                cnt_we = (cmd_reg == wcht_pkg::CMD_INSERT);
                vld_we = (cmd_reg == wcht_pkg::CMD_DELETE);
                state_next = wcht_pkg::S_OUT;
            end
            wcht_pkg::S_OUT:
                state_next = out_load ? wcht_pkg::S_IDLE : wcht_pkg::S_OUT;
            default:
                state_next = wcht_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= wcht_pkg::S_CLEAR;
            hash_reg     <= wcht_pkg::HASH_SEED;
            len_reg      <= '0;
            long_reg     <= 1'b0;
            total_reg    <= '0;
            distinct_reg <= '0;
            ovalid_reg   <= 1'b0;
            slot_reg     <= '0;
            probe_reg    <= '0;
            idx_reg      <= '0;
            m_st_reg     <= '0;
            m_slot_reg   <= '0;
            m_cnt_reg    <= '0;
            m_tot_reg    <= '0;
            m_dis_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            probe_reg <= probe_next;
            idx_reg   <= idx_next;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                ovalid_reg <= 1'b0;
            if (acc)
            begin
                if (len_reg < LW'(WORD_BYTES))
                    len_reg <= len_reg + LW'(1);
                else
                    long_reg <= 1'b1;
                hash_reg <= hash_new;
            end
            case (state_reg)
                wcht_pkg::S_SLOT_RD:
                begin
                    if (long_reg)
                        ost_reg <= wcht_pkg::ST_LONG;
                    else if (probe_reg == PW'(TABLE_ENTRIES))
                        ost_reg <= (cmd_reg == wcht_pkg::CMD_INSERT) ?
                                   wcht_pkg::ST_FULL : wcht_pkg::ST_MISS;
                    oslot_reg <= '0;
                    ocnt_reg  <= '0;
                end
                wcht_pkg::S_SLOT_WAIT:
                begin
                    if (!vld_rdata && cmd_reg != wcht_pkg::CMD_INSERT)
                        ost_reg <= wcht_pkg::ST_MISS;
                end
                wcht_pkg::S_STORE:
                begin
                    if (state_next == wcht_pkg::S_OUT)
                    begin
                        ost_reg   <= wcht_pkg::ST_NEW;
                        oslot_reg <= slot_reg;
                        ocnt_reg  <= 32'd1;
                        if (total_reg != wcht_pkg::SAT32)
                            total_reg <= total_reg + 32'd1;
                        if (distinct_reg != wcht_pkg::SAT32)
                            distinct_reg <= distinct_reg + 32'd1;
                    end
                end
                wcht_pkg::S_COUNT:
                begin
                    oslot_reg <= slot_reg;
                    if (cmd_reg == wcht_pkg::CMD_INSERT)
                    begin
                        ost_reg  <= wcht_pkg::ST_INC;
                        ocnt_reg <= cnt_wdata;
                        if (total_reg != wcht_pkg::SAT32)
                            total_reg <= total_reg + 32'd1;
                    end
                    else if (cmd_reg == wcht_pkg::CMD_DELETE)
                    begin
                        ost_reg  <= wcht_pkg::ST_DELETED;
                        ocnt_reg <= '0;
                    end
                    else
                    begin
                        ost_reg  <= wcht_pkg::ST_FOUND;
                        ocnt_reg <= cnt_rdata;
                    end
                end
                wcht_pkg::S_OUT:
                begin
                    if (out_load)
                    begin
                        m_st_reg   <= ost_reg;
                        m_slot_reg <= oslot_reg;
                        m_cnt_reg  <= ocnt_reg;
                        m_tot_reg  <= total_reg;
                        m_dis_reg  <= distinct_reg;
                        hash_reg   <= wcht_pkg::HASH_SEED;
                        len_reg    <= '0;
                        long_reg   <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cmd_reg <= s_axis_tuser;
            if (len_reg < LW'(WORD_BYTES))
                wbuf_reg[len_reg[BW-1:0]] <= s_axis_tdata;
        end
    end

    logic [9:0] slot_out;
    assign slot_out = 10'(m_slot_reg);

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tuser  = m_st_reg;
    assign m_axis_tdata  = {6'd0, m_dis_reg, m_tot_reg, m_cnt_reg, slot_out};

    // no byte is taken while the table is being walked
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> (state_reg == wcht_pkg::S_IDLE))
        else $error("input accepted while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (m_axis_tvalid && len_reg == '0))
        else $error("result not raised or word state not cleared");
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata})))
        else $error("result changed while stalled");
endmodule : word_count_hash_table
`default_nettype wire

[hw/rtl/wcht_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wcht_ram
// ram with one write port and one registered read port
// ----------------------------------------------------------------------------
module wcht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule : wcht_ram
`default_nettype wire
